// ===== sv/poly_voice_allocator_macros.svh =====
// Assertion helpers for the voice allocator checkers.
`ifndef POLY_VOICE_ALLOCATOR_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define PVA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pva_pkg.sv =====
`timescale 1ns / 1ps

package pva_pkg;

    localparam int OP_W      = 2;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int FIN_W     = 3;
    localparam int ACT_W     = 2;
    localparam int IDX_OUT_W = 3;

    // request operations
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISHED = 2'd2;

    // result actions
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd3;

    // request travelling down the voice chain
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic [FIN_W-1:0]  fin;
    } t_req;

    // search results gathered along the chain
    typedef struct packed {
        logic              match_hit;
        logic              free_hit;
        logic [NOTE_W-1:0] cap_note;
        logic [VEL_W-1:0]  cap_vel;
    } t_hit;

    // update broadcast to every voice
    typedef struct packed {
        logic              on;
        logic              fin;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_cmd;

endpackage

// ===== sv/pva_cell.sv =====
`timescale 1ns / 1ps

module pva_cell import pva_pkg::*; #(
    parameter int VOICE_COUNT = 8,
    parameter int AGE_BITS    = 8,
    parameter int CELL_IDX    = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // scan in
    input  logic                           i_tok,
    input  t_req                           i_req,
    input  t_hit                           i_hit,
    input  logic [$clog2(VOICE_COUNT)-1:0] i_match_idx,
    input  logic [$clog2(VOICE_COUNT)-1:0] i_free_idx,
    input  logic [AGE_BITS-1:0]            i_old_age,
    input  logic [$clog2(VOICE_COUNT)-1:0] i_old_idx,
    // scan out
    output logic                           o_tok,
    output t_req                           o_req,
    output t_hit                           o_hit,
    output logic [$clog2(VOICE_COUNT)-1:0] o_match_idx,
    output logic [$clog2(VOICE_COUNT)-1:0] o_free_idx,
    output logic [AGE_BITS-1:0]            o_old_age,
    output logic [$clog2(VOICE_COUNT)-1:0] o_old_idx,
    // commit
    input  t_cmd                           i_cmd,
    input  logic [$clog2(VOICE_COUNT)-1:0] i_pick
);

    localparam int IDXW = $clog2(VOICE_COUNT);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(CELL_IDX);

    // voice state
    logic [NOTE_W-1:0]   r_note;
    logic [VEL_W-1:0]    r_vel;
    logic                r_active;
    logic [AGE_BITS-1:0] r_age;

    // scan stage
    logic                r_tok;
    t_req                r_req;
    t_hit                r_hit;
    logic [IDXW-1:0]     r_match_idx, r_free_idx, r_old_idx;
    logic [AGE_BITS-1:0] r_old_age;

    t_hit                n_hit;
    logic [IDXW-1:0]     n_match_idx, n_free_idx, n_old_idx;
    logic [AGE_BITS-1:0] n_old_age;

    logic mine;
    assign mine = (i_pick == MY_IDX);

    always_comb begin
        n_hit       = i_hit;
        n_match_idx = i_match_idx;
        n_free_idx  = i_free_idx;
        n_old_age   = i_old_age;
        n_old_idx   = i_old_idx;
        // lowest matching note
        if (!i_hit.match_hit && (r_note == i_req.note)) begin
            n_hit.match_hit = 1'b1;
            n_match_idx     = MY_IDX;
            if (i_req.op == OP_NOTE_OFF) begin
                n_hit.cap_note = r_note;
                n_hit.cap_vel  = r_vel;
            end
        end
        // lowest idle voice
        if (!i_hit.free_hit && !r_active) begin
            n_hit.free_hit = 1'b1;
            n_free_idx     = MY_IDX;
        end
        // oldest voice, later index wins a tie
        if (i_old_age <= r_age) begin
            n_old_age = r_age;
            n_old_idx = MY_IDX;
        end
        if ((i_req.op == OP_FINISHED) && (32'(i_req.fin) == CELL_IDX)) begin
            n_hit.cap_note = r_note;
            n_hit.cap_vel  = r_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_req       <= i_req;
            r_hit       <= n_hit;
            r_match_idx <= n_match_idx;
            r_free_idx  <= n_free_idx;
            r_old_age   <= n_old_age;
            r_old_idx   <= n_old_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note   <= '0;
            r_vel    <= '0;
            r_active <= 1'b0;
            r_age    <= '0;
        end else begin
            if (i_cmd.on) begin
                if (mine) begin
                    r_note   <= i_cmd.note;
                    r_vel    <= i_cmd.vel;
                    r_active <= 1'b1;
                    r_age    <= '0;
                end else if (r_age != '1) begin
                    r_age <= r_age + 1'b1;
                end
            end
            if (i_cmd.fin && mine) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_tok       = r_tok;
    assign o_req       = r_req;
    assign o_hit       = r_hit;
    assign o_match_idx = r_match_idx;
    assign o_free_idx  = r_free_idx;
    assign o_old_age   = r_old_age;
    assign o_old_idx   = r_old_idx;

endmodule

// ===== sv/poly_voice_allocator.sv =====
`timescale 1ns / 1ps
// Polyphonic voice allocator: maps note events onto a pool of VOICE_COUNT voices.
// Request channel: start with i_operation, i_note_number, i_note_velocity and
//   i_finished_voice; a request is taken at a clock edge where start is high
//   and busy is low.
// Result channel: o_done is high for exactly one cycle with o_action,
//   o_voice_index, o_voice_note, o_voice_velocity, o_stolen, o_retriggered.
//   Every request gives one result, a nothing-done result being all zeros.
//   The receiver has no way to stall; results must be taken as they come.
// The request travels down the row of voice cells, one cell per cycle, and
//   o_done rises once it has left the last cell and the result is registered.
// No new request is taken until the current one has passed through the cell
//   row and the chosen voice has been written back.
// busy stays high from the accepting edge until the voice update is done.
// Reset (i_rst_n low, synchronous) clears every voice: note, velocity,
//   active flag and age go to zero, and the block comes up idle.
// Note on: lowest voice with the same note, else lowest idle voice, else the
//   oldest voice (highest index on a tie); every other voice ages by one, saturating.
module poly_voice_allocator import pva_pkg::*; #(
    parameter int VOICE_COUNT = 8,
    parameter int AGE_BITS    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [NOTE_W-1:0]    i_note_number,
    input  logic [VEL_W-1:0]     i_note_velocity,
    input  logic [FIN_W-1:0]     i_finished_voice,
    output logic                 o_done,
    output logic [ACT_W-1:0]     o_action,
    output logic [IDX_OUT_W-1:0] o_voice_index,
    output logic [NOTE_W-1:0]    o_voice_note,
    output logic [VEL_W-1:0]     o_voice_velocity,
    output logic                 o_stolen,
    output logic                 o_retriggered
);

    localparam int IDXW = $clog2(VOICE_COUNT);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] r_state, n_state;

    // chain links: entry k feeds cell k, entry VOICE_COUNT leaves the last cell
    logic                tok       [VOICE_COUNT+1];
    t_req                req       [VOICE_COUNT+1];
    t_hit                hit       [VOICE_COUNT+1];
    logic [IDXW-1:0]     match_idx [VOICE_COUNT+1];
    logic [IDXW-1:0]     free_idx  [VOICE_COUNT+1];
    logic [AGE_BITS-1:0] old_age   [VOICE_COUNT+1];
    logic [IDXW-1:0]     old_idx   [VOICE_COUNT+1];

    t_cmd            r_cmd, n_cmd;
    logic [IDXW-1:0] r_pick, n_pick;

    logic                 r_done;
    logic [ACT_W-1:0]     r_action, n_action;
    logic [IDX_OUT_W-1:0] r_idx, n_idx;
    logic [NOTE_W-1:0]    r_note, n_note;
    logic [VEL_W-1:0]     r_vel, n_vel;
    logic                 r_stolen, n_stolen;
    logic                 r_retrig, n_retrig;

    logic accept, scan_end;
    t_req last_req;
    t_hit last_hit;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign scan_end = (r_state == ST_SCAN) && tok[VOICE_COUNT];
    assign last_req = req[VOICE_COUNT];
    assign last_hit = hit[VOICE_COUNT];

    // head of the chain: fresh request, nothing found yet
    assign tok[0]       = accept;
    assign req[0]       = '{op: i_operation, note: i_note_number,
                            vel: i_note_velocity, fin: i_finished_voice};
    assign hit[0]       = '0;
    assign match_idx[0] = '0;
    assign free_idx[0]  = '0;
    assign old_age[0]   = '0;
    assign old_idx[0]   = '0;

    for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_cell
        pva_cell #(
            .VOICE_COUNT (VOICE_COUNT),
            .AGE_BITS    (AGE_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok[g]),
            .i_req       (req[g]),
            .i_hit       (hit[g]),
            .i_match_idx (match_idx[g]),
            .i_free_idx  (free_idx[g]),
            .i_old_age   (old_age[g]),
            .i_old_idx   (old_idx[g]),
            .o_tok       (tok[g+1]),
            .o_req       (req[g+1]),
            .o_hit       (hit[g+1]),
            .o_match_idx (match_idx[g+1]),
            .o_free_idx  (free_idx[g+1]),
            .o_old_age   (old_age[g+1]),
            .o_old_idx   (old_idx[g+1]),
            .i_cmd       (r_cmd),
            .i_pick      (r_pick)
        );
    end

    // decide the voice once the request has seen every cell
    always_comb begin
        n_action = ACT_NONE;
        n_idx    = '0;
        n_note   = '0;
        n_vel    = '0;
        n_stolen = 1'b0;
        n_retrig = 1'b0;
        n_cmd    = '0;
        n_pick   = '0;
        unique case (last_req.op)
            OP_NOTE_ON: begin
                if (last_hit.match_hit) begin
                    n_pick   = match_idx[VOICE_COUNT];
                    n_retrig = 1'b1;
                end else if (last_hit.free_hit) begin
                    n_pick = free_idx[VOICE_COUNT];
                end else begin
                    n_pick   = old_idx[VOICE_COUNT];
                    n_stolen = 1'b1;
                end
                n_action = ACT_START;
                n_idx    = IDX_OUT_W'(n_pick);
                n_note   = last_req.note;
                n_vel    = last_req.vel;
                n_cmd.on   = 1'b1;
                n_cmd.note = last_req.note;
                n_cmd.vel  = last_req.vel;
            end
            OP_NOTE_OFF: begin
                // note off changes no voice state
                if (last_hit.match_hit) begin
                    n_pick   = match_idx[VOICE_COUNT];
                    n_action = ACT_RELEASE;
                    n_idx    = IDX_OUT_W'(n_pick);
                    n_note   = last_hit.cap_note;
                    n_vel    = last_hit.cap_vel;
                end
            end
            OP_FINISHED: begin
                // voice numbers past the pool are dropped
                if (32'(last_req.fin) < VOICE_COUNT) begin
                    n_pick    = IDXW'(last_req.fin);
                    n_action  = ACT_FREE;
                    n_idx     = IDX_OUT_W'(n_pick);
                    n_note    = last_hit.cap_note;
                    n_vel     = last_hit.cap_vel;
                    n_cmd.fin = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept)   n_state = ST_SCAN;
            ST_SCAN:   if (scan_end) n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_cmd   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= scan_end;
            // command lives for the commit cycle only
            r_cmd   <= scan_end ? n_cmd : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_end) begin
            r_pick   <= n_pick;
            r_action <= n_action;
            r_idx    <= n_idx;
            r_note   <= n_note;
            r_vel    <= n_vel;
            r_stolen <= n_stolen;
            r_retrig <= n_retrig;
        end
    end

    assign o_done           = r_done;
    assign o_action         = r_action;
    assign o_voice_index    = r_idx;
    assign o_voice_note     = r_note;
    assign o_voice_velocity = r_vel;
    assign o_stolen         = r_stolen;
    assign o_retriggered    = r_retrig;

endmodule

// ===== sv/pva_checker.sv =====
`timescale 1ns / 1ps
`include "poly_voice_allocator_macros.svh"

module pva_checker import pva_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input logic [ACT_W-1:0]     o_action,
    input logic [IDX_OUT_W-1:0] o_voice_index,
    input logic [NOTE_W-1:0]    o_voice_note,
    input logic [VEL_W-1:0]     o_voice_velocity,
    input logic                 o_stolen,
    input logic                 o_retriggered
);

    `PVA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy low after accept")
    `PVA_ASSERT_IMPL(a_done_busy, i_clk, i_rst_n, o_done, busy && $past(busy), "result while idle")
    `PVA_ASSERT_IMPL(a_none_zero, i_clk, i_rst_n, o_done && (o_action == ACT_NONE), (o_voice_index == '0) && (o_voice_note == '0) && (o_voice_velocity == '0) && !o_stolen && !o_retriggered, "nonzero idle result")
    `PVA_ASSERT_IMPL(a_flags_start, i_clk, i_rst_n, o_done && (o_action != ACT_START), !o_stolen && !o_retriggered, "flags outside note on")
    `PVA_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, o_done, !(o_stolen && o_retriggered), "stolen and retriggered")

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (.*);
